// File: hw/rtl/cll_pkg.sv
// cll_pkg: shared types and constants of the c_like_lexer block
// lexer modes, token kinds, error codes, the step result struct
// no dependencies
`timescale 1ns / 1ps

package cll_pkg;

   typedef enum logic [4:0] {
      M_IDLE, M_IDENT, M_STR, M_STR_ESC, M_ZERO, M_DEC, M_HEX0, M_HEX,
      M_BIN0, M_BIN, M_OCT, M_CH_OPEN, M_CH_ESC, M_CH_CLOSE, M_OP2,
      M_SLASH, M_SKIPLINE, M_BLOCK, M_BLOCK_STAR
   } mode_type;

   localparam logic [5:0] K_END    = 6'd0;
   localparam logic [5:0] K_IDENT  = 6'd1;
   localparam logic [5:0] K_NUMBER = 6'd2;
   localparam logic [5:0] K_CHAR   = 6'd3;
   localparam logic [5:0] K_STRING = 6'd4;
   localparam logic [5:0] K_TEXT   = 6'd5;
   localparam logic [5:0] K_ERROR  = 6'd6;
   localparam logic [5:0] K_KW0    = 6'd7;
   localparam logic [5:0] K_SLASH  = 6'd27;

   localparam logic [3:0] E_NONE    = 4'd0;
   localparam logic [3:0] E_STRING  = 4'd1;
   localparam logic [3:0] E_HEX     = 4'd2;
   localparam logic [3:0] E_BIN     = 4'd3;
   localparam logic [3:0] E_CH_CUT  = 4'd4;
   localparam logic [3:0] E_CH_EMPT = 4'd5;
   localparam logic [3:0] E_CH_OPEN = 4'd6;
   localparam logic [3:0] E_UNKNOWN = 4'd7;
   localparam logic [3:0] E_BAR     = 4'd8;
   localparam logic [3:0] E_COMMENT = 4'd9;

   // one token without position
   typedef struct packed {
      logic [5:0]  kind;
      logic [31:0] value;
      logic [7:0]  text;
      logic [3:0]  err;
   } tok_type;

   // what one step produces
   typedef struct packed {
      logic    has0;
      tok_type tok0;
      logic    has1;
      tok_type tok1;
   } step_type;

   function automatic tok_type mk_tok(logic [5:0] kind, logic [31:0] value,
                                      logic [7:0] text, logic [3:0] err);
      tok_type t;
      t.kind = kind; t.value = value; t.text = text; t.err = err;
      return t;
   endfunction

   function automatic logic [5:0] single_op(logic [7:0] c);
      logic [5:0] k;
      case (c)
         "+": k = 6'd22;  "-": k = 6'd24;  "*": k = 6'd26;  "/": k = 6'd27;
         "%": k = 6'd28;  ">": k = 6'd29;  "<": k = 6'd31;  "=": k = 6'd33;
         "&": k = 6'd35;  "!": k = 6'd38;  ",": k = 6'd40;  ":": k = 6'd41;
         ";": k = 6'd42;  "(": k = 6'd43;  ")": k = 6'd44;  "[": k = 6'd45;
         "]": k = 6'd46;  "{": k = 6'd47;  "}": k = 6'd48;
         default: k = 6'd0;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] double_op(logic [7:0] a, logic [7:0] b);
      logic [5:0] k;
      k = 6'd0;
      if (a == "+" && b == "+") k = 6'd23;
      if (a == "-" && b == "-") k = 6'd25;
      if (a == ">" && b == "=") k = 6'd30;
      if (a == "<" && b == "=") k = 6'd32;
      if (a == "=" && b == "=") k = 6'd34;
      if (a == "&" && b == "&") k = 6'd36;
      if (a == "|" && b == "|") k = 6'd37;
      if (a == "!" && b == "=") k = 6'd39;
      return k;
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   // escape translation shared by strings and char literals
   function automatic logic [7:0] unescape(logic [7:0] b);
      logic [7:0] r;
      case (b)
         "n": r = 8'd10;
         "t": r = 8'd9;
         "0": r = 8'd0;
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/cll_kw_match.sv
// cll_kw_match: keyword lookup on the first identifier bytes
// depends on cll_pkg
`timescale 1ns / 1ps

module cll_kw_match
   import cll_pkg::*;
#(
   parameter int KEYWORD_MAX_LEN = 8,
   parameter int LEN_BITS = 5
) (
   input  logic [KEYWORD_MAX_LEN*8-1:0] kw_buf,
   input  logic [LEN_BITS-1:0]          kw_len,
   output logic [5:0]                   kind
);

   localparam int NKW = 15;
   localparam logic [8*8-1:0] KW_NAME [NKW] = '{
      64'h00000000_00746e69, 64'h00000000_72616863, 64'h00000000_64696f76,
      64'h00006e72_65747865, 64'h00000000_00006669, 64'h00000000_65736c65,
      64'h00006863_74697773, 64'h00000000_65736163, 64'h00746c75_61666564,
      64'h00000065_6c696877, 64'h00000000_00006f64, 64'h00000000_00726f66,
      64'h0000006b_61657262, 64'h65756e69_746e6f63, 64'h00006e72_75746572};
   localparam int KW_LEN [NKW] = '{3, 4, 4, 6, 2, 4, 6, 4, 7, 5, 2, 3, 5, 8, 6};

   // bytes past the length are zero in the buffer, so a full compare works
   always_comb begin
      logic [KEYWORD_MAX_LEN*8-1:0] nm;
      kind = K_IDENT;
      for (int k = NKW - 1; k >= 0; k--) begin
         nm = '0;
         nm[63:0] = KW_NAME[k];
         if (kw_len == LEN_BITS'(KW_LEN[k]) && kw_buf == nm)
            kind = K_KW0 + 6'(k);
      end
   end

endmodule

// File: hw/rtl/cll_step.sv
// cll_step: mode register update and result decode for one input
// depends on cll_pkg and cll_kw_match
`timescale 1ns / 1ps

module cll_step
   import cll_pkg::*;
#(
   parameter int KEYWORD_MAX_LEN = 8,
   parameter int LEN_BITS = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [7:0]                   src_byte,
   input  logic                         end_of_input,
   input  logic                         report_errors,
   output step_type                     step
);

   mode_type                     mode_ff, mode_in;
   logic [31:0]                  acc_ff, acc_in;
   logic [KEYWORD_MAX_LEN*8-1:0] kbuf_ff, kbuf_in;
   logic [LEN_BITS-1:0]          klen_ff, klen_in;
   logic [7:0]                   pend_ff, pend_in;
   logic [5:0]                   kw_kind;

   cll_kw_match #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN), .LEN_BITS(LEN_BITS)) u_kw (
      .kw_buf(kbuf_ff), .kw_len(klen_ff), .kind(kw_kind));

   // mode decode: first part finishes the open token, second restarts
   always_comb begin
      logic       restart;
      logic       e0, e1;
      tok_type    t0, t1;
      logic [4:0] d;
      logic [7:0] b;
      b = src_byte;
      mode_in = mode_ff; acc_in = acc_ff; kbuf_in = kbuf_ff;
      klen_in = klen_ff; pend_in = pend_ff;
      e0 = 1'b0; e1 = 1'b0;
      t0 = mk_tok(K_END, 32'd0, 8'd0, E_NONE);
      t1 = t0;
      restart = 1'b0;
      d = 5'h1f;
      if (is_digit(b)) d = {1'b0, b[3:0]};
      else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
         d = {1'b0, b[3:0] + 4'd9};
      if (end_of_input) begin
         case (mode_ff)
            M_IDENT: begin e0 = 1'b1; t0.kind = kw_kind; end
            M_STR, M_STR_ESC: begin e0 = report_errors; t0.kind = K_ERROR;
               t0.err = E_STRING; end
            M_ZERO, M_DEC, M_OCT, M_HEX, M_BIN: begin e0 = 1'b1;
               t0.kind = K_NUMBER; t0.value = acc_ff; end
            M_HEX0: begin e0 = report_errors; t0.kind = K_ERROR; t0.err = E_HEX; end
            M_BIN0: begin e0 = report_errors; t0.kind = K_ERROR; t0.err = E_BIN; end
            M_CH_OPEN, M_CH_ESC: begin e0 = report_errors; t0.kind = K_ERROR;
               t0.err = E_CH_CUT; end
            M_CH_CLOSE: begin e0 = report_errors; t0.kind = K_ERROR;
               t0.err = E_CH_OPEN; end
            M_OP2: begin
               if (pend_ff == "|") begin e0 = report_errors; t0.kind = K_ERROR;
                  t0.err = E_BAR; end
               else begin e0 = 1'b1; t0.kind = single_op(pend_ff); end
            end
            M_SLASH: begin e0 = 1'b1; t0.kind = K_SLASH; end
            M_BLOCK, M_BLOCK_STAR: begin e0 = report_errors; t0.kind = K_ERROR;
               t0.err = E_COMMENT; end
            default: ;
         endcase
         e1 = 1'b1;
         t1 = mk_tok(K_END, 32'd0, 8'd0, E_NONE);
         mode_in = M_IDLE; acc_in = '0; kbuf_in = '0; klen_in = '0; pend_in = '0;
      end else begin
         case (mode_ff)
            M_IDENT: begin
               if (is_alpha(b) || is_digit(b)) begin
                  for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                     if (klen_ff == LEN_BITS'(i)) kbuf_in[i*8 +: 8] = b;
                  if (klen_ff <= LEN_BITS'(KEYWORD_MAX_LEN)) klen_in = klen_ff + 1'b1;
                  e0 = 1'b1; t0.kind = K_TEXT; t0.text = b;
               end else begin
                  e0 = 1'b1; t0.kind = kw_kind; restart = 1'b1;
               end
            end
            M_STR: begin
               if (b == "\"") begin e0 = 1'b1; t0.kind = K_STRING; mode_in = M_IDLE; end
               else if (b == "\\") mode_in = M_STR_ESC;
               else if (b == 8'd10) begin e0 = report_errors; t0.kind = K_ERROR;
                  t0.err = E_STRING; mode_in = M_IDLE; end
               else begin e0 = 1'b1; t0.kind = K_TEXT; t0.text = b; end
            end
            M_STR_ESC: begin
               mode_in = M_STR;
               if (b != 8'd10) begin e0 = 1'b1; t0.kind = K_TEXT; t0.text = unescape(b); end
            end
            M_ZERO: begin
               if (b == "x") mode_in = M_HEX0;
               else if (b == "b") mode_in = M_BIN0;
               else if (b >= "0" && b <= "7") begin
                  mode_in = M_OCT; acc_in = {29'd0, b[2:0]};
               end else begin
                  e0 = 1'b1; t0.kind = K_NUMBER; restart = 1'b1;
               end
            end
            M_DEC: begin
               if (is_digit(b)) acc_in = (acc_ff << 3) + (acc_ff << 1) + {28'd0, b[3:0]};
               else begin e0 = 1'b1; t0.kind = K_NUMBER; t0.value = acc_ff;
                  restart = 1'b1; end
            end
            M_OCT: begin
               if (b >= "0" && b <= "7") acc_in = {acc_ff[28:0], b[2:0]};
               else begin e0 = 1'b1; t0.kind = K_NUMBER; t0.value = acc_ff;
                  restart = 1'b1; end
            end
            M_HEX0, M_HEX: begin
               if (!d[4]) begin
                  acc_in = (mode_ff == M_HEX0) ? {28'd0, d[3:0]} : {acc_ff[27:0], d[3:0]};
                  mode_in = M_HEX;
               end else begin
                  restart = 1'b1;
                  if (mode_ff == M_HEX0) begin e0 = report_errors; t0.kind = K_ERROR;
                     t0.err = E_HEX; end
                  else begin e0 = 1'b1; t0.kind = K_NUMBER; t0.value = acc_ff; end
               end
            end
            M_BIN0, M_BIN: begin
               if (b == "0" || b == "1") begin
                  acc_in = (mode_ff == M_BIN0) ? {31'd0, b[0]} : {acc_ff[30:0], b[0]};
                  mode_in = M_BIN;
               end else begin
                  restart = 1'b1;
                  if (mode_ff == M_BIN0) begin e0 = report_errors; t0.kind = K_ERROR;
                     t0.err = E_BIN; end
                  else begin e0 = 1'b1; t0.kind = K_NUMBER; t0.value = acc_ff; end
               end
            end
            M_CH_OPEN: begin
               if (b == "\\") mode_in = M_CH_ESC;
               else if (b == 8'd10) begin e0 = report_errors; t0.kind = K_ERROR;
                  t0.err = E_CH_CUT; restart = 1'b1; end
               else if (b == "'") begin e0 = report_errors; t0.kind = K_ERROR;
                  t0.err = E_CH_EMPT; mode_in = M_IDLE; end
               else begin pend_in = b; mode_in = M_CH_CLOSE; end
            end
            M_CH_ESC: begin
               if (b == 8'd10) begin e0 = report_errors; t0.kind = K_ERROR;
                  t0.err = E_CH_CUT; restart = 1'b1; end
               else begin pend_in = unescape(b); mode_in = M_CH_CLOSE; end
            end
            M_CH_CLOSE: begin
               if (b == "'") begin e0 = 1'b1; t0.kind = K_CHAR;
                  t0.value = {24'd0, pend_ff}; mode_in = M_IDLE; end
               else begin e0 = report_errors; t0.kind = K_ERROR; t0.err = E_CH_OPEN;
                  restart = 1'b1; end
            end
            M_OP2: begin
               if (double_op(pend_ff, b) != 6'd0) begin
                  e0 = 1'b1; t0.kind = double_op(pend_ff, b); mode_in = M_IDLE;
               end else begin
                  restart = 1'b1;
                  if (pend_ff == "|") begin e0 = report_errors; t0.kind = K_ERROR;
                     t0.err = E_BAR; end
                  else begin e0 = 1'b1; t0.kind = single_op(pend_ff); end
               end
            end
            M_SLASH: begin
               if (b == "/") mode_in = M_SKIPLINE;
               else if (b == "*") mode_in = M_BLOCK;
               else begin e0 = 1'b1; t0.kind = K_SLASH; restart = 1'b1; end
            end
            M_SKIPLINE: if (b == 8'd10) mode_in = M_IDLE;
            M_BLOCK: if (b == "*") mode_in = M_BLOCK_STAR;
            M_BLOCK_STAR: begin
               if (b == "/") mode_in = M_IDLE;
               else if (b != "*") mode_in = M_BLOCK;
            end
            default: restart = 1'b1;
         endcase
         // start of a new token from idle
         if (restart) begin
            mode_in = M_IDLE;
            if (b == " " || b == 8'd9 || b == 8'd10) ;
            else if (is_alpha(b)) begin
               // fresh buffer so bytes past the length stay zero
               mode_in = M_IDENT; kbuf_in = '0; kbuf_in[7:0] = b; klen_in = LEN_BITS'(1);
               e1 = 1'b1; t1.kind = K_TEXT; t1.text = b;
            end else if (b == "\"") mode_in = M_STR;
            else if (b == "0") begin mode_in = M_ZERO; acc_in = '0; end
            else if (is_digit(b)) begin mode_in = M_DEC; acc_in = {28'd0, b[3:0]}; end
            else if (b == "'") mode_in = M_CH_OPEN;
            else if (b == "#") mode_in = M_SKIPLINE;
            else if (b == "/") mode_in = M_SLASH;
            else if (b == "+" || b == "-" || b == ">" || b == "<" || b == "=" ||
                     b == "&" || b == "|" || b == "!") begin
               mode_in = M_OP2; pend_in = b;
            end else if (single_op(b) != 6'd0) begin
               e1 = 1'b1; t1.kind = single_op(b);
            end else begin
               e1 = report_errors; t1.kind = K_ERROR; t1.err = E_UNKNOWN;
            end
         end
      end
      step.has0 = e0; step.tok0 = t0; step.has1 = e1; step.tok1 = t1;
   end

   // lexer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE; acc_ff <= '0; kbuf_ff <= '0; klen_ff <= '0; pend_ff <= '0;
      end else if (advance) begin
         mode_ff <= mode_in; acc_ff <= acc_in; kbuf_ff <= kbuf_in;
         klen_ff <= klen_in; pend_ff <= pend_in;
      end
   end

   // the identifier length never runs past one beyond the buffer
   assert property (@(posedge clock) disable iff (reset)
      klen_ff <= LEN_BITS'(KEYWORD_MAX_LEN + 1))
      else $error("identifier length overflow");
   // an end mark always leaves the lexer idle
   assert property (@(posedge clock) disable iff (reset)
      advance && end_of_input |=> mode_ff == M_IDLE)
      else $error("end mark did not clear mode");
   // the end mark always yields the END token
   assert property (@(posedge clock) disable iff (reset)
      end_of_input |-> step.has1 && step.tok1.kind == K_END)
      else $error("missing end token");

endmodule

// File: hw/rtl/c_like_lexer_top.sv
// c_like_lexer_top: streaming lexer, one source byte per request
// depends on cll_pkg and cll_step
//
//  channel  dir  signals                          payload
//  req      in   req_tvalid/tready/tdata          src_byte [7:0], end_of_input [8]
//  rsp      out  rsp_tvalid/tready/tdata/tlast    see tdata comment
//  csr      in   csr_valid/ready/data             report_errors
//
// a request is decoded combinationally; its results (up to two) land in a
// two-entry output queue. one result leaves per cycle while rsp_tready is
// high: one request per cycle while each gives at most one result, and a
// request giving two holds off the next. queue space sets request ready.
// reset (synchronous) returns the lexer to idle, line 1, column 0.
`timescale 1ns / 1ps

module c_like_lexer_top
   import cll_pkg::*;
#(
   parameter int KEYWORD_MAX_LEN = 8,
   parameter int LINE_BITS = 16,
   parameter int COLUMN_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // src_byte[7:0], end_of_input[8], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // token_kind[5:0], token_value[37:6], text_byte[45:38], error_code[49:46],
   // line_number, column_number above, zero filled
   output logic [((78 - 28 + LINE_BITS + COLUMN_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   localparam int LEN_BITS = $clog2(KEYWORD_MAX_LEN + 2);
   localparam int PW = 50 + LINE_BITS + COLUMN_BITS;
   localparam int DW = ((PW + 7) / 8) * 8;
   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

   logic                   rep_ff;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic                   nl_ff;
   logic                   advance;
   step_type               step;
   logic [PW:0]            q_ff [2];
   logic [1:0]             cnt_ff;

   assign csr_ready = 1'b1;
   // accept when the queue is empty, or holds one entry that is popped at the same time
   assign req_tready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_tready);
   assign advance = req_tvalid && req_tready;

   cll_step #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN), .LEN_BITS(LEN_BITS)) u_step (
      .clock(clock), .reset(reset), .advance(advance),
      .src_byte(req_tdata[7:0]), .end_of_input(req_tdata[8]),
      .report_errors(rep_ff), .step(step));

   // position of this byte
   always_comb begin
      line_in = line_ff; col_in = col_ff;
      if (nl_ff) begin
         if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
         col_in = '0;
      end else if (!req_tdata[8] && req_tdata[7:0] != 8'd10) begin
         if (col_ff != COL_MAX) col_in = col_ff + 1'b1;
      end
   end

   // config and position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rep_ff <= 1'b0; line_ff <= LINE_BITS'(1); col_ff <= '0; nl_ff <= 1'b0;
      end else begin
         if (csr_valid) rep_ff <= csr_data;
         if (advance) begin
            if (req_tdata[8]) begin
               line_ff <= LINE_BITS'(1); col_ff <= '0; nl_ff <= 1'b0;
            end else begin
               line_ff <= line_in; col_ff <= col_in;
               nl_ff <= req_tdata[7:0] == 8'd10;
            end
         end
      end
   end

   // output queue, entry 0 at the head
   always_ff @(posedge clock) begin
      logic             pop;
      logic [1:0]       c;
      logic [PW:0]      r0, r1;
      pop = rsp_tvalid && rsp_tready;
      r0 = {!step.has1, col_in, line_in, step.tok0.err, step.tok0.text,
            step.tok0.value, step.tok0.kind};
      r1 = {1'b1, col_in, line_in, step.tok1.err, step.tok1.text,
            step.tok1.value, step.tok1.kind};
      if (reset) cnt_ff <= 2'd0;
      else begin
         c = cnt_ff;
         if (pop) begin q_ff[0] <= q_ff[1]; c = c - 2'd1; end
         if (advance) begin
            if (step.has0 && step.has1) begin
               q_ff[c[0]] <= r0; q_ff[1] <= r1; c = c + 2'd2;
            end else if (step.has0) begin
               q_ff[c[0]] <= r0; c = c + 2'd1;
            end else if (step.has1) begin
               q_ff[c[0]] <= r1; c = c + 2'd1;
            end
         end
         cnt_ff <= c;
      end
   end

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata = DW'(q_ff[0][PW-1:0]);
   assign rsp_tlast = q_ff[0][PW];

   // queue never overfills
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   // a request is only taken with room in the queue
   assert property (@(posedge clock) disable iff (reset)
      advance |-> cnt_ff == 2'd0 || rsp_tready)
      else $error("request taken without room");
   // a newline byte moves the next byte to column zero
   assert property (@(posedge clock) disable iff (reset)
      advance && !req_tdata[8] && req_tdata[7:0] == 8'd10 |=> nl_ff)
      else $error("newline not tracked");

endmodule
